FILE: hw/rtl/sip_pkg.sv
// ----------------------------------------------------------------------------
// sip_pkg: shared types and constants for the SipHash stream core
// Holds the chain word type, the SipRound function, command codes passed from
// the controller to the datapath, and the register indexes of the CSR port.
// ----------------------------------------------------------------------------
package sip_pkg;

   localparam logic [63:0] IV0 = 64'h736f6d6570736575;
   localparam logic [63:0] IV1 = 64'h646f72616e646f6d;
   localparam logic [63:0] IV2 = 64'h6c7967656e657261;
   localparam logic [63:0] IV3 = 64'h7465646279746573;
   localparam logic [63:0] FIN_MARK = 64'h00000000000000ff;

   // CSR register indexes
   localparam logic [1:0] REG_KEY_LOW     = 2'd0;
   localparam logic [1:0] REG_KEY_HIGH    = 2'd1;
   localparam logic [1:0] REG_COMP_ROUNDS = 2'd2;
   localparam logic [1:0] REG_FIN_ROUNDS  = 2'd3;

   // Datapath operations
   localparam logic [2:0] OP_NONE       = 3'd0;
   localparam logic [2:0] OP_ACCEPT     = 3'd1;
   localparam logic [2:0] OP_ROUND      = 3'd2;
   localparam logic [2:0] OP_MIX        = 3'd3;
   localparam logic [2:0] OP_LOAD_FINAL = 3'd4;
   localparam logic [2:0] OP_FIN_XOR    = 3'd5;
   localparam logic [2:0] OP_OUT        = 3'd6;

   typedef struct packed {
      logic [63:0] v3;
      logic [63:0] v2;
      logic [63:0] v1;
      logic [63:0] v0;
   } chain_type;

   typedef struct packed {
      logic [2:0] op;
   } cmd_type;

   typedef struct packed {
      logic       word_done;
      logic       out_free;
      logic [7:0] compress_rounds;
      logic [7:0] finish_rounds;
   } status_type;

   function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] r);
      return (x << r) | (x >> (7'd64 - {1'b0, r}));
   endfunction

   function automatic chain_type sip_round(input chain_type v);
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
      logic [63:0] d;
      chain_type   r;
      a = v.v0;
      b = v.v1;
      c = v.v2;
      d = v.v3;
      a = a + b; b = rotl(b, 6'd13); b = b ^ a; a = rotl(a, 6'd32);
      c = c + d; d = rotl(d, 6'd16); d = d ^ c;
      a = a + d; d = rotl(d, 6'd21); d = d ^ a;
      c = c + b; b = rotl(b, 6'd17); b = b ^ c; c = rotl(c, 6'd32);
      r.v0 = a;
      r.v1 = b;
      r.v2 = c;
      r.v3 = d;
      return r;
   endfunction

endpackage

FILE: hw/rtl/sip_dpath.sv
// ----------------------------------------------------------------------------
// sip_dpath: SipHash datapath
// Chain words, byte packing, length count, CSRs, the SipRound unit and the
// result register, all driven by the controller's command.
// ----------------------------------------------------------------------------
module sip_dpath (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [63:0]        csr_wdata,
   input  logic [7:0]         req_data_byte,
   input  logic               req_byte_present,
   input  sip_pkg::cmd_type    cmd,
   output sip_pkg::status_type status,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [63:0]        rsp_tdata
);
   import sip_pkg::*;

   chain_type   chain_ff, chain_in, base, init;
   logic [63:0] m_ff, m_in;
   logic [55:0] pending_ff, pending_in, p_base;
   logic [2:0]  count_ff, count_in, c_base;
   logic [7:0]  len_ff, len_in, l_base;
   logic        open_ff, open_in;
   logic [63:0] key_low_ff, key_high_ff;
   logic [7:0]  compress_rounds_ff, finish_rounds_ff;
   logic [63:0] hash_ff, hash_in;
   logic        valid_ff, valid_in;
   logic [63:0] word_in, final_word;
   logic        word_done;

   always_comb begin
      init.v0 = key_low_ff ^ IV0;
      init.v1 = key_high_ff ^ IV1;
      init.v2 = key_low_ff ^ IV2;
      init.v3 = key_high_ff ^ IV3;
      base    = open_ff ? chain_ff : init;
      p_base  = open_ff ? pending_ff : '0;
      c_base  = open_ff ? count_ff : '0;
      l_base  = open_ff ? len_ff : '0;
      word_in = {req_data_byte, p_base};
      word_done  = req_byte_present && (c_base == 3'd7);
      final_word = {len_ff, pending_ff};
   end

   always_comb begin
      chain_in   = chain_ff;
      m_in       = m_ff;
      pending_in = pending_ff;
      count_in   = count_ff;
      len_in     = len_ff;
      open_in    = open_ff;
      hash_in    = hash_ff;
      valid_in   = valid_ff && !rsp_tready;
      case (cmd.op)
         OP_ACCEPT: begin
            chain_in   = base;
            pending_in = p_base;
            count_in   = c_base;
            len_in     = l_base;
            open_in    = 1'b1;
            if (req_byte_present) begin
               len_in = l_base + 8'd1;
               if (c_base == 3'd7) begin
                  chain_in.v3 = base.v3 ^ word_in;
                  m_in        = word_in;
                  pending_in  = '0;
                  count_in    = '0;
               end else begin
                  // free lanes above the count are zero, so overwrite the lane
                  for (int i = 0; i < 7; i++) begin
                     if (c_base == 3'(i)) pending_in[8*i +: 8] = req_data_byte;
                  end
                  count_in = c_base + 3'd1;
               end
            end
         end
         OP_ROUND: chain_in = sip_round(chain_ff);
         OP_MIX:   chain_in.v0 = chain_ff.v0 ^ m_ff;
         OP_LOAD_FINAL: begin
            chain_in.v3 = chain_ff.v3 ^ final_word;
            m_in        = final_word;
         end
         OP_FIN_XOR: begin
            chain_in.v0 = chain_ff.v0 ^ m_ff;
            chain_in.v2 = chain_ff.v2 ^ FIN_MARK;
         end
         OP_OUT: begin
            hash_in  = chain_ff.v0 ^ chain_ff.v1 ^ chain_ff.v2 ^ chain_ff.v3;
            valid_in = 1'b1;
            open_in  = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      chain_ff   <= chain_in;
      m_ff       <= m_in;
      pending_ff <= pending_in;
      count_ff   <= count_in;
      len_ff     <= len_in;
      hash_ff    <= hash_in;
      if (reset) begin
         open_ff            <= 1'b0;
         valid_ff           <= 1'b0;
         key_low_ff         <= '0;
         key_high_ff        <= '0;
         compress_rounds_ff <= 8'd2;
         finish_rounds_ff   <= 8'd4;
      end else begin
         open_ff  <= open_in;
         valid_ff <= valid_in;
         if (csr_we) begin
            case (csr_index)
               REG_KEY_LOW:     key_low_ff         <= csr_wdata;
               REG_KEY_HIGH:    key_high_ff        <= csr_wdata;
               REG_COMP_ROUNDS: compress_rounds_ff <= csr_wdata[7:0];
               REG_FIN_ROUNDS:  finish_rounds_ff   <= csr_wdata[7:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign status.word_done       = word_done;
   assign status.out_free        = !valid_ff || rsp_tready;
   assign status.compress_rounds = compress_rounds_ff;
   assign status.finish_rounds   = finish_rounds_ff;
   assign rsp_tvalid             = valid_ff;
   assign rsp_tdata              = hash_ff;

endmodule

FILE: hw/rtl/sip_ctrl.sv
// ----------------------------------------------------------------------------
// sip_ctrl: SipHash sequencer
// Accepts beats, counts SipRounds and steps the datapath through compression,
// finalisation and result hand-off.
// ----------------------------------------------------------------------------
module sip_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_tlast,
   input  sip_pkg::status_type status,
   output sip_pkg::cmd_type    cmd
);
   import sip_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_ROUND = 2'd1;
   localparam logic [1:0] S_LOADF = 2'd2;
   localparam logic [1:0] S_OUT   = 2'd3;

   localparam logic [1:0] PH_WORD = 2'd0;
   localparam logic [1:0] PH_FINW = 2'd1;
   localparam logic [1:0] PH_FIN  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic [7:0] left_ff, left_in;
   logic       last_ff, last_in;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      left_in  = left_ff;
      last_in  = last_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op  = OP_ACCEPT;
               last_in = req_tlast;
               if (status.word_done) begin
                  state_in = S_ROUND;
                  phase_in = PH_WORD;
                  left_in  = status.compress_rounds;
               end else if (req_tlast) begin
                  state_in = S_LOADF;
               end
            end
         end
         S_ROUND: begin
            if (left_ff == 8'd0) begin
               case (phase_ff)
                  PH_WORD: begin
                     cmd.op   = OP_MIX;
                     state_in = last_ff ? S_LOADF : S_IDLE;
                  end
                  PH_FINW: begin
                     cmd.op   = OP_FIN_XOR;
                     phase_in = PH_FIN;
                     left_in  = status.finish_rounds;
                  end
                  PH_FIN: state_in = S_OUT;
                  default: state_in = S_IDLE;
               endcase
            end else begin
               cmd.op  = OP_ROUND;
               left_in = left_ff - 8'd1;
            end
         end
         S_LOADF: begin
            cmd.op   = OP_LOAD_FINAL;
            state_in = S_ROUND;
            phase_in = PH_FINW;
            left_in  = status.compress_rounds;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.op   = OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_WORD;
         left_ff  <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         left_ff  <= left_in;
         last_ff  <= last_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

FILE: hw/rtl/siphash_cd_stream_core.sv
// ----------------------------------------------------------------------------
// siphash_cd_stream_core: keyed SipHash-c-d over a byte stream
// Bytes stream in one beat at a time; a beat with tlast closes the message and
// yields one 64-bit hash beat on the response side.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake               payload
//  req       in   req_tvalid/req_tready   tdata[7:0] data_byte, tuser byte_present,
//                                         tlast end_of_message
//  rsp       out  rsp_tvalid/rsp_tready   tdata[63:0] hash_value
//  csr       in   csr_we                  csr_index, csr_wdata (write only)
//
//  Ready: a plain byte beat leaves req_tready high; a beat completing an
//  8-byte word drops it through c SipRounds and the mix; a tlast beat drops
//  it through the final load, c + d rounds and the hand-off (longer if it
//  completes a word too), paced by the single SipRound unit, one round per cycle.
//  Reset: synchronous, active high; key 0, c = 2, d = 4, no message open.
//  Stalls: a waiting hash sits in the output register while new bytes are
//  taken; only a second hash ready before the first is taken holds the block.
//
module siphash_cd_stream_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_present
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [63:0] hash_value
);
   import sip_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: owns the handshake on the request side and the round count
   sip_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: chain words, byte packing, CSRs and the result register
   sip_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_data_byte    (req_tdata),
      .req_byte_present (req_tuser),
      .cmd              (cmd),
      .status           (status),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata)
   );

endmodule

FILE: hw/rtl/sip_checker.sv
// ----------------------------------------------------------------------------
// sip_checker: port-level checks for the SipHash stream core
// Watches the top-level ports and is attached by the bind at the foot.
// ----------------------------------------------------------------------------
module sip_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat dropped or changed while stalled");

   // no result straight out of reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a closing beat starts finalisation, so the request side goes busy
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("request side ready right after closing beat");

   // a fresh result is loaded only from the hand-off state, when requests wait
   a_rise_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without finalisation");

endmodule

bind siphash_cd_stream_core sip_checker u_sip_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
